// File: src/ptld_pkg.sv
// Package for the prefix term list decoder.
// Holds the buffer size default and the marker byte codes; no dependencies.
package ptld_pkg;

  // Default capacity of the term and pending-run buffers, in bytes.
  localparam int unsigned MaxTermBytes = 32;

  // Marker bytes in the encoded stream.
  localparam logic [7:0] ByteEndTerm = 8'h00;  // run becomes a new term
  localparam logic [7:0] ByteEndExt  = 8'h01;  // run extends the previous term

endpackage : ptld_pkg

// File: src/prefix_term_list_decoder.sv
// Top level of the prefix (front-coded) term list decoder.
// Depends on ptld_pkg and ptld_ram (pending-run store and last-term store).
//
// Usage:
//   Input channel: one encoded byte per item (byte_value_i, record_start_i),
//   taken when in_valid_i is high and in_stall_o is low. record_start_i
//   clears all decoding state before its byte is decoded.
//   Output channel: one decoded term byte per item, taken when out_valid_o is
//   high and out_stall_i is low; term_last_o marks the end of a term.
//   Timing: an ordinary byte is written into the pending store in the cycle
//   it is accepted and the next byte can follow in the next cycle. After a
//   terminator the input stalls while the run is copied and the term read
//   out: the copy reads one byte per cycle, then writes the last byte and
//   hands over; the read-out through the registered RAM read gives one byte
//   per cycle while the output is not stalled. An empty term stalls the input
//   in the copy and result states, a corrupt marker in the result state only,
//   each giving one result. Both stores have one read and one write port.
//   Reset clears lengths and flags; store contents are kept. An output stall
//   holds the output register and lengthens the input stall; input is taken
//   again once the final byte of the term is in the output register.
module prefix_term_list_decoder
  import ptld_pkg::*;
#(
  parameter int unsigned MAX_TERM_BYTES = MaxTermBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_value_i,
  input  logic       record_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] term_byte_o,
  output logic       term_last_o,
  output logic       term_empty_o,
  output logic       term_truncated_o,
  output logic       record_corrupt_o
);

  localparam int unsigned Aw = (MAX_TERM_BYTES > 1) ? $clog2(MAX_TERM_BYTES) : 1;
  localparam int unsigned Lw = $clog2(MAX_TERM_BYTES + 1);
  localparam logic [Lw-1:0] MaxLen = Lw'(MAX_TERM_BYTES);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCopy = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;
  localparam logic [1:0] StOne  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [Lw-1:0] llen_q, llen_d;
  logic [Lw-1:0] plen_q, plen_d;
  logic          povf_q, povf_d;
  logic          have_q, have_d;
  logic          halt_q, halt_d;
  logic          ltrunc_q, ltrunc_d;
  logic          sp_corrupt_q, sp_corrupt_d;
  logic [Lw-1:0] cp_n_q, cp_n_d;
  logic [Lw-1:0] cp_rd_q, cp_rd_d;
  logic [Aw-1:0] cp_wr_q, cp_wr_d;
  logic          cpv_q, cpv_d;
  logic [Lw-1:0] em_idx_q, em_idx_d;
  logic          rdv_q, rdv_d;
  logic          rd_last_q, rd_last_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;
  logic          out_empty_q, out_empty_d;
  logic          out_trunc_q, out_trunc_d;
  logic          out_corrupt_q, out_corrupt_d;

  // RAM ports
  logic          pend_we, pend_re;
  logic [Aw-1:0] pend_waddr, pend_raddr;
  logic [7:0]    pend_rdata;
  logic          last_we, last_re;
  logic [Aw-1:0] last_raddr;
  logic [7:0]    last_rdata;

  // State as seen after an optional record start
  logic [Lw-1:0] e_llen, e_plen, room, ext_n;
  logic          e_povf, e_have, e_halt, e_ltrunc;
  logic          out_free, ld;

  assign e_llen   = record_start_i ? '0 : llen_q;
  assign e_plen   = record_start_i ? '0 : plen_q;
  assign e_povf   = record_start_i ? 1'b0 : povf_q;
  assign e_have   = record_start_i ? 1'b0 : have_q;
  assign e_halt   = record_start_i ? 1'b0 : halt_q;
  assign e_ltrunc = record_start_i ? 1'b0 : ltrunc_q;
  assign room     = MaxLen - e_llen;
  assign ext_n    = (e_plen < room) ? e_plen : room;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d       = state_q;
    llen_d        = llen_q;
    plen_d        = plen_q;
    povf_d        = povf_q;
    have_d        = have_q;
    halt_d        = halt_q;
    ltrunc_d      = ltrunc_q;
    sp_corrupt_d  = sp_corrupt_q;
    cp_n_d        = cp_n_q;
    cp_rd_d       = cp_rd_q;
    cp_wr_d       = cp_wr_q;
    cpv_d         = cpv_q;
    em_idx_d      = em_idx_q;
    rdv_d         = rdv_q;
    rd_last_d     = rd_last_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;
    out_empty_d   = out_empty_q;
    out_trunc_d   = out_trunc_q;
    out_corrupt_d = out_corrupt_q;
    pend_we       = 1'b0;
    pend_waddr    = e_plen[Aw-1:0];
    pend_re       = 1'b0;
    pend_raddr    = cp_rd_q[Aw-1:0];
    last_we       = 1'b0;
    last_re       = 1'b0;
    last_raddr    = em_idx_q[Aw-1:0];
    ld            = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          llen_d   = e_llen;
          plen_d   = e_plen;
          povf_d   = e_povf;
          have_d   = e_have;
          halt_d   = e_halt;
          ltrunc_d = e_ltrunc;
          if (!e_halt) begin
            priority if (byte_value_i == ByteEndExt) begin
              if (!e_have) begin
                halt_d       = 1'b1;
                plen_d       = '0;
                povf_d       = 1'b0;
                sp_corrupt_d = 1'b1;
                state_d      = StOne;
              end else begin
                cp_n_d   = ext_n;
                cp_rd_d  = '0;
                cp_wr_d  = e_llen[Aw-1:0];
                cpv_d    = 1'b0;
                llen_d   = e_llen + ext_n;
                ltrunc_d = e_ltrunc | e_povf | (e_plen > room);
                plen_d   = '0;
                povf_d   = 1'b0;
                state_d  = StCopy;
              end
            end else if (byte_value_i == ByteEndTerm) begin
              cp_n_d   = e_plen;
              cp_rd_d  = '0;
              cp_wr_d  = '0;
              cpv_d    = 1'b0;
              llen_d   = e_plen;
              ltrunc_d = e_povf;
              have_d   = 1'b1;
              plen_d   = '0;
              povf_d   = 1'b0;
              state_d  = StCopy;
            end else begin
              if (e_plen < MaxLen) begin
                pend_we = 1'b1;
                plen_d  = e_plen + Lw'(1);
              end else begin
                povf_d = 1'b1;
              end
            end
          end
        end
      end
      StCopy: begin
        // read pending[i] this cycle, write last[base + i] the next
        if (cpv_q) begin
          last_we = 1'b1;
          cp_wr_d = cp_wr_q + Aw'(1);
        end
        if (cp_rd_q < cp_n_q) begin
          pend_re = 1'b1;
          cp_rd_d = cp_rd_q + Lw'(1);
          cpv_d   = 1'b1;
        end else begin
          cpv_d = 1'b0;
          if (!cpv_q) begin
            em_idx_d     = '0;
            rdv_d        = 1'b0;
            sp_corrupt_d = 1'b0;
            state_d      = (llen_q == '0) ? StOne : StEmit;
          end
        end
      end
      StEmit: begin
        ld = rdv_q && out_free;
        if (ld) begin
          out_valid_d   = 1'b1;
          out_byte_d    = last_rdata;
          out_last_d    = rd_last_q;
          out_empty_d   = 1'b0;
          out_trunc_d   = ltrunc_q;
          out_corrupt_d = 1'b0;
          rdv_d         = 1'b0;
        end
        if (!rdv_q || ld) begin
          if (em_idx_q < llen_q) begin
            last_re   = 1'b1;
            em_idx_d  = em_idx_q + Lw'(1);
            rdv_d     = 1'b1;
            rd_last_d = ((em_idx_q + Lw'(1)) == llen_q);
          end else begin
            state_d = StIdle;
          end
        end
      end
      StOne: begin
        // single result: empty term or corrupt record
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_byte_d    = '0;
          out_last_d    = 1'b1;
          out_empty_d   = !sp_corrupt_q;
          out_trunc_d   = !sp_corrupt_q && ltrunc_q;
          out_corrupt_d = sp_corrupt_q;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      llen_q      <= '0;
      plen_q      <= '0;
      povf_q      <= 1'b0;
      have_q      <= 1'b0;
      halt_q      <= 1'b0;
      ltrunc_q    <= 1'b0;
      cp_n_q      <= '0;
      cp_rd_q     <= '0;
      cpv_q       <= 1'b0;
      em_idx_q    <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      llen_q      <= llen_d;
      plen_q      <= plen_d;
      povf_q      <= povf_d;
      have_q      <= have_d;
      halt_q      <= halt_d;
      ltrunc_q    <= ltrunc_d;
      cp_n_q      <= cp_n_d;
      cp_rd_q     <= cp_rd_d;
      cpv_q       <= cpv_d;
      em_idx_q    <= em_idx_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_corrupt_q  <= sp_corrupt_d;
    cp_wr_q       <= cp_wr_d;
    rd_last_q     <= rd_last_d;
    out_byte_q    <= out_byte_d;
    out_last_q    <= out_last_d;
    out_empty_q   <= out_empty_d;
    out_trunc_q   <= out_trunc_d;
    out_corrupt_q <= out_corrupt_d;
  end

  ptld_ram #(
    .Width(8),
    .Depth(MAX_TERM_BYTES)
  ) u_pend_ram (
    .clk_i  (clk_i),
    .we_i   (pend_we),
    .waddr_i(pend_waddr),
    .wdata_i(byte_value_i),
    .re_i   (pend_re),
    .raddr_i(pend_raddr),
    .rdata_o(pend_rdata)
  );

  ptld_ram #(
    .Width(8),
    .Depth(MAX_TERM_BYTES)
  ) u_last_ram (
    .clk_i  (clk_i),
    .we_i   (last_we),
    .waddr_i(cp_wr_q),
    .wdata_i(pend_rdata),
    .re_i   (last_re),
    .raddr_i(last_raddr),
    .rdata_o(last_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign term_byte_o      = out_byte_q;
  assign term_last_o      = out_last_q;
  assign term_empty_o     = out_empty_q;
  assign term_truncated_o = out_trunc_q;
  assign record_corrupt_o = out_corrupt_q;

endmodule : prefix_term_list_decoder

// File: src/ptld_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while the read enable is low. No dependencies.
module ptld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : ptld_ram

// File: tb/tb_prefix_term_list_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for prefix_term_list_decoder: directed records, then random records.
// Depends on ptld_pkg and the decoder RTL; a scoreboard class predicts the decoded term bytes.
module tb_prefix_term_list_decoder;
  import ptld_pkg::*;

  localparam int unsigned TermMax    = MaxTermBytes;
  localparam int unsigned NumItems   = 180;
  localparam int unsigned TailCycles = 2 * TermMax + 16;

  typedef struct packed {
    logic [7:0] tbyte;
    logic       last;
    logic       empty;
    logic       trunc;
    logic       corrupt;
  } term_res_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [7:0] byte_value_i   = 8'h00;
  logic       record_start_i = 1'b0;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] term_byte_o;
  logic       term_last_o;
  logic       term_empty_o;
  logic       term_truncated_o;
  logic       record_corrupt_o;

  prefix_term_list_decoder #(
    .MAX_TERM_BYTES(TermMax)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .byte_value_i    (byte_value_i),
    .record_start_i  (record_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .term_byte_o     (term_byte_o),
    .term_last_o     (term_last_o),
    .term_empty_o    (term_empty_o),
    .term_truncated_o(term_truncated_o),
    .record_corrupt_o(record_corrupt_o)
  );

  class term_scoreboard;
    logic [7:0]  term_buf[TermMax];
    int unsigned term_len;
    logic [7:0]  run_buf[TermMax];
    int unsigned run_len;
    bit          run_ovf;
    bit          have_term;
    bit          halted;
    bit          term_cut;
    term_res_t   expected_bytes[$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_terms;
    int unsigned n_cut;
    int unsigned n_corrupt;

    function new();
      term_len  = 0;
      run_len   = 0;
      run_ovf   = 0;
      have_term = 0;
      halted    = 0;
      term_cut  = 0;
      n_errors  = 0;
      n_checked = 0;
      n_terms   = 0;
      n_cut     = 0;
      n_corrupt = 0;
    endfunction

    function void push_term();
      if (term_len == 0) begin
        expected_bytes.push_back(term_res_t'{8'h00, 1'b1, 1'b1, term_cut, 1'b0});
      end else begin
        for (int unsigned i = 0; i < term_len; i++)
          expected_bytes.push_back(term_res_t'{term_buf[i], (i + 1 == term_len), 1'b0,
                                               term_cut, 1'b0});
      end
      n_terms++;
      if (term_cut) n_cut++;
    endfunction

    // Returns 0 when the byte falls into a halted (corrupt) record.
    function bit decode_byte(logic [7:0] b, logic start);
      bit          cut;
      int unsigned len;
      if (start) begin
        term_len  = 0;
        run_len   = 0;
        run_ovf   = 0;
        have_term = 0;
        halted    = 0;
        term_cut  = 0;
      end
      if (halted) return 0;
      if (b == ByteEndExt) begin
        if (!have_term) begin
          expected_bytes.push_back(term_res_t'{8'h00, 1'b1, 1'b0, 1'b0, 1'b1});
          halted  = 1;
          run_len = 0;
          run_ovf = 0;
          n_corrupt++;
          return 1;
        end
        cut = term_cut || run_ovf;
        len = term_len;
        for (int unsigned i = 0; i < run_len; i++) begin
          if (len < TermMax) begin
            term_buf[len] = run_buf[i];
            len++;
          end else begin
            cut = 1;
          end
        end
        term_len = len;
        term_cut = cut;
        run_len  = 0;
        run_ovf  = 0;
        push_term();
      end else if (b == ByteEndTerm) begin
        for (int unsigned i = 0; i < run_len; i++) term_buf[i] = run_buf[i];
        term_len  = run_len;
        term_cut  = run_ovf;
        have_term = 1;
        run_len   = 0;
        run_ovf   = 0;
        push_term();
      end else if (run_len < TermMax) begin
        run_buf[run_len] = b;
        run_len++;
      end else begin
        run_ovf = 1;
      end
      return 1;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        n_errors++;
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_term_byte(term_res_t got);
      term_res_t want;
      n_checked++;
      if (expected_bytes.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected item: expected none, got byte %0h last %0b", $time,
                 got.tbyte, got.last);
        return;
      end
      want = expected_bytes.pop_front();
      check_field("term_byte", want.tbyte, got.tbyte);
      check_field("term_last", 8'(want.last), 8'(got.last));
      check_field("term_empty", 8'(want.empty), 8'(got.empty));
      check_field("term_truncated", 8'(want.trunc), 8'(got.trunc));
      check_field("record_corrupt", 8'(want.corrupt), 8'(got.corrupt));
    endfunction
  endclass

  term_scoreboard sb;
  bit             idle_on    = 1'b1;
  int unsigned    stall_left = 0;
  int unsigned    rx_roll;
  int unsigned    n_taken    = 0;
  int unsigned    n_records  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output side: check every accepted item, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_term_byte(term_res_t'{term_byte_o, term_last_o, term_empty_o,
                                     term_truncated_o, record_corrupt_o});
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      rx_roll = $urandom_range(0, 99);
      if (idle_on && rx_roll < 22)
        stall_left = (rx_roll < 3) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(logic [7:0] b, logic start);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    byte_value_i   <= b;
    record_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    void'(sb.decode_byte(b, start));
    n_taken++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_bytes.size() != 0);
  endtask

  // mode 1: over-long first run; mode 2: extensions that overflow the buffer
  function automatic int unsigned pick_run(int unsigned mode, int unsigned j);
    int unsigned r;
    if (mode == 1) return (j == 0) ? $urandom_range(33, 40) : $urandom_range(3, 12);
    if (mode == 2) return (j == 0) ? $urandom_range(18, 24) : $urandom_range(12, 20);
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 5);
    if (r < 88) return $urandom_range(6, 20);
    return $urandom_range(25, 40);
  endfunction

  task automatic gen_record(int unsigned mode);
    logic [7:0]  seq[$];
    int unsigned nterms;
    int unsigned run;
    int unsigned r;
    logic        start;
    if (mode == 0 && $urandom_range(0, 99) < 15) begin
      // noise: markers and arbitrary bytes, maybe continuing the current record
      run   = $urandom_range(1, 12);
      start = 1'($urandom_range(0, 1));
      for (int unsigned k = 0; k < run; k++) begin
        r = $urandom_range(0, 9);
        if (r < 3) seq.push_back(ByteEndTerm);
        else if (r < 5) seq.push_back(ByteEndExt);
        else seq.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      start  = 1'b1;
      nterms = (mode != 0) ? 3 : $urandom_range(1, 5);
      for (int unsigned j = 0; j < nterms; j++) begin
        run = pick_run(mode, j);
        for (int unsigned k = 0; k < run; k++) seq.push_back(8'($urandom_range(2, 255)));
        if (j == 0)
          seq.push_back((mode == 0 && $urandom_range(0, 99) < 6) ? ByteEndExt : ByteEndTerm);
        else
          seq.push_back((mode != 0 || $urandom_range(0, 1)) ? ByteEndExt : ByteEndTerm);
      end
      // unterminated tail, dropped at the next record start
      if ($urandom_range(0, 99) < 20) begin
        run = $urandom_range(1, 4);
        for (int unsigned k = 0; k < run; k++) seq.push_back(8'($urandom_range(2, 255)));
      end
    end
    for (int unsigned k = 0; k < seq.size(); k++) send_item(seq[k], start && k == 0);
    n_records++;
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(8'h41, 1'b1);
    send_item(8'h42, 1'b0);
    send_item(ByteEndTerm, 1'b0);
    send_item(ByteEndTerm, 1'b0);   // empty term
    send_item(8'hFF, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(ByteEndExt, 1'b0);    // extends the empty term
    send_item(ByteEndExt, 1'b0);    // empty run repeats the term
    send_item(8'h7E, 1'b0);
    send_item(8'h80, 1'b0);         // left unterminated
    send_item(ByteEndExt, 1'b1);    // extension before any term
    send_item(ByteEndTerm, 1'b0);   // rest of the record is ignored
    send_item(8'h33, 1'b0);
    send_item(ByteEndExt, 1'b0);
    send_item(ByteEndTerm, 1'b1);   // record start on a terminator
    send_item(8'h03, 1'b1);
    send_item(8'hFE, 1'b0);
    send_item(ByteEndTerm, 1'b0);
    wait_drained();

    gen_record(1);
    gen_record(2);
    while (n_taken < NumItems) begin
      idle_on = ($urandom_range(0, 4) != 0);
      gen_record(0);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d bytes in %0d records: %0d terms (%0d truncated), %0d corrupt records",
             n_taken, n_records, sb.n_terms, sb.n_cut, sb.n_corrupt);
    $display("Checked %0d items, mismatches: %0d", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d items still expected", sb.expected_bytes.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
